// ===== sv/lcg_pkg.sv =====
// lcg_pkg: constants, types and tables for the loiter circle guidance block.
// No dependencies.
package lcg_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STAGES   = 26;   // result bits of the square root

    localparam int AW = 26;              // angle width, 2^-24 rad (|a| < 2^26)
    localparam int CW = 60;              // CORDIC x/y width (|v| < 2^26 * 2^32 * 1.7)
    localparam int YW = 40;              // yaw sum width: gain term reaches 2^36

    localparam logic signed [AW+1:0] ANG_PI      = 28'sd52707179;
    localparam logic signed [AW+1:0] ANG_HALF_PI = 28'sd26353589;

    localparam logic [2:0] REG_WP_NORTH     = 3'd0;
    localparam logic [2:0] REG_WP_EAST      = 3'd1;
    localparam logic [2:0] REG_WP_ALT       = 3'd2;
    localparam logic [2:0] REG_ORBIT_RADIUS = 3'd3;
    localparam logic [2:0] REG_ERROR_LIMIT  = 3'd4;
    localparam logic [2:0] REG_YAW_GAIN     = 3'd5;
    localparam logic [2:0] REG_THROTTLE_SET = 3'd6;

    typedef struct packed {
        logic signed [23:0] pos_north;
        logic signed [23:0] pos_east;
        logic signed [23:0] altitude;
    } lcg_in_t;

    typedef struct packed {
        logic signed [15:0] yaw_cmd;
        logic signed [15:0] pitch_cmd;
        logic        [15:0] throttle_cmd;
    } lcg_out_t;

    typedef struct packed {
        logic signed [23:0] wp_north;
        logic signed [23:0] wp_east;
        logic signed [23:0] wp_alt;
        logic        [22:0] orbit_radius;
        logic        [15:0] error_limit;
        logic        [15:0] yaw_gain;
        logic        [15:0] throttle_set;
    } lcg_cfg_t;

    function automatic logic signed [AW+1:0] atan_entry(input int i);
        logic signed [AW+1:0] t;
        begin
            unique case (i)
                0: t = 28'sd13176795;
                1: t = 28'sd7778716;
                2: t = 28'sd4110060;
                3: t = 28'sd2086331;
                4: t = 28'sd1047214;
                5: t = 28'sd524117;
                6: t = 28'sd262123;
                7: t = 28'sd131069;
                default: t = (i < 24) ? (28'sd65536 >>> (i - 8)) : 28'sd0;
            endcase
            return t;
        end
    endfunction

    function automatic logic signed [15:0] to_q13(input logic signed [YW-1:0] v);
        logic signed [YW-1:0] r;
        begin
            r = (v + 32'sd1024) >>> 11;
            if (r > 32'sd32767)
                return 16'sh7fff;
            else if (r < -32'sd32768)
                return 16'sh8000;
            else
                return r[15:0];
        end
    endfunction

endpackage

// ===== sv/lcg_stream_if.sv =====
// lcg_stream_if: valid/ready channel carrying one request of type T.
// No dependencies.
interface lcg_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/lcg_sqrt.sv =====
// lcg_sqrt: pipelined restoring integer square root, one result bit per stage.
// Depends on lcg_pkg. Carries a side payload of type T alongside.
module lcg_sqrt #(parameter type T = logic)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2*lcg_pkg::SQRT_STAGES-1:0] in_val,
    input  T                          in_side,
    output logic                      out_valid,
    output logic [lcg_pkg::SQRT_STAGES-1:0] out_root,
    output T                          out_side
);
    import lcg_pkg::*;
    localparam int N = SQRT_STAGES;

    logic [N:0]          v_reg;
    logic [2*N-1:0]      rem_reg  [N+1];
    logic [N-1:0]        root_reg [N+1];
    T                    side_reg [N+1];

    always_comb
    begin
        v_reg[0]    = in_valid;
        rem_reg[0]  = in_val;
        root_reg[0] = '0;
        side_reg[0] = in_side;
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [N+1:0] trial;
        logic [N+1:0] rem_hi;
        logic [2*N-1:0] rem_next;
        logic [N-1:0]   root_next;
        always_comb
        begin
            // remainder window for bit (N-1-s)
            rem_hi   = (N+2)'(rem_reg[s] >> (2*(N-1-s)));
            trial    = {root_reg[s], 2'b01} & {(N+2){1'b1}};
            rem_next = rem_reg[s];
            root_next = root_reg[s];
            if (rem_hi >= trial)
            begin
                rem_next = rem_reg[s] - ((2*N)'(trial) << (2*(N-1-s)));
                root_next = {root_reg[s][N-2:0], 1'b1};
            end
            else
            begin
                root_next = {root_reg[s][N-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_next;
                root_reg[s+1] <= root_next;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];
endmodule

// ===== sv/lcg_cordic.sv =====
// lcg_cordic: pipelined vectoring CORDIC atan2, one micro-rotation per stage.
// Depends on lcg_pkg. Carries a side payload of type T alongside.
module lcg_cordic #(parameter type T = logic)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [lcg_pkg::AW:0] in_y,
    input  logic signed [lcg_pkg::AW:0] in_x,
    input  T                            in_side,
    output logic                        out_valid,
    output logic signed [lcg_pkg::AW+1:0] out_ang,
    output T                            out_side
);
    import lcg_pkg::*;
    localparam int N = CORDIC_STAGES;

    logic                 v_reg [N+2];
    logic signed [CW-1:0] x_reg [N+2];
    logic signed [CW-1:0] y_reg [N+2];
    logic signed [AW+1:0] z_reg [N+2];
    T                     side_reg [N+2];

    // pre-rotation stage
    logic signed [CW-1:0] x0, y0;
    logic signed [AW+1:0] z0;
    always_comb
    begin
        x0 = CW'(in_x) <<< 32;
        y0 = CW'(in_y) <<< 32;
        z0 = '0;
        if (in_x < 0)
        begin
            z0 = (in_y >= 0) ? ANG_PI : -ANG_PI;
            x0 = -x0;
            y0 = -y0;
        end
        if (in_x == 0 && in_y == 0)
        begin
            x0 = '0;
            y0 = '0;
        end
    end

    always_comb
    begin
        v_reg[0] = 1'b0;
        x_reg[0] = '0;
        y_reg[0] = '0;
        z_reg[0] = '0;
        side_reg[0] = in_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[1] <= 1'b0;
        else if (en)
            v_reg[1] <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[1] <= x0;
            y_reg[1] <= y0;
            z_reg[1] <= z0;
            side_reg[1] <= in_side;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic signed [CW-1:0] xn, yn;
        logic signed [AW+1:0] zn;
        logic zero_vec;
        always_comb
        begin
            // zero vector keeps y == 0, x == 0: must stay at angle 0
            zero_vec = (x_reg[s+1] == 0) && (y_reg[s+1] == 0);
            if (y_reg[s+1] >= 0)
            begin
                xn = x_reg[s+1] + (y_reg[s+1] >>> s);
                yn = y_reg[s+1] - (x_reg[s+1] >>> s);
                zn = z_reg[s+1] + atan_entry(s);
            end
            else
            begin
                xn = x_reg[s+1] - (y_reg[s+1] >>> s);
                yn = y_reg[s+1] + (x_reg[s+1] >>> s);
                zn = z_reg[s+1] - atan_entry(s);
            end
            if (zero_vec)
            begin
                xn = '0;
                yn = '0;
                zn = z_reg[s+1];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+2] <= 1'b0;
            else if (en)
                v_reg[s+2] <= v_reg[s+1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s+2] <= xn;
                y_reg[s+2] <= yn;
                z_reg[s+2] <= zn;
                side_reg[s+2] <= side_reg[s+1];
            end
        end
    end

    assign out_valid = v_reg[N+1];
    assign out_ang   = z_reg[N+1];
    assign out_side  = side_reg[N+1];
endmodule

// ===== sv/loiter_circle_guidance.sv =====
// loiter_circle_guidance: top level; register file, differences, sqrt, CORDIC, yaw law.
// Depends on lcg_pkg, lcg_stream_if, lcg_sqrt, lcg_cordic.
//
// Takes one position request per clock while the output is not stalled and returns one
// command request per position, in order. The pipe holds SQRT_STAGES + CORDIC_STAGES + 4
// register stages (46 at defaults); the depth is set by the bit-per-stage square root
// followed by the stage-per-rotation CORDIC. The whole pipe advances whenever the output
// register is empty or taken, so a stall at the output freezes every stage and loses
// nothing. Registers are to be written by the user only while no request is in flight;
// the block itself does not enforce this.
module loiter_circle_guidance
(
    input  logic        clk,
    input  logic        rst_n,
    lcg_stream_if.sink   pos,
    lcg_stream_if.source cmd,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import lcg_pkg::*;

    lcg_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wp_north     <= -24'sd16000;
            cfg_reg.wp_east      <= 24'sd16000;
            cfg_reg.wp_alt       <= 24'sd16000;
            cfg_reg.orbit_radius <= 23'd22627;
            cfg_reg.error_limit  <= 16'd160;
            cfg_reg.yaw_gain     <= 16'd655;
            cfg_reg.throttle_set <= 16'd45875;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WP_NORTH:     cfg_reg.wp_north     <= cfg_wdata;
                REG_WP_EAST:      cfg_reg.wp_east      <= cfg_wdata;
                REG_WP_ALT:       cfg_reg.wp_alt       <= cfg_wdata;
                REG_ORBIT_RADIUS: cfg_reg.orbit_radius <= cfg_wdata[22:0];
                REG_ERROR_LIMIT:  cfg_reg.error_limit  <= cfg_wdata[15:0];
                REG_YAW_GAIN:     cfg_reg.yaw_gain     <= cfg_wdata[15:0];
                REG_THROTTLE_SET: cfg_reg.throttle_set <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic out_valid_reg;
    logic en;
    assign en = !out_valid_reg || cmd.ready;
    assign pos.ready = en;

    // stage A: differences and squares
    typedef struct packed {
        logic signed [AW:0] de;
        logic signed [AW:0] dn;
        logic signed [AW:0] dh;
    } sideA_t;

    logic   a_valid_reg;
    sideA_t a_side_reg;
    logic [2*SQRT_STAGES-1:0] a_sq_reg;
    logic [2*SQRT_STAGES-1:0] a_sq1_reg;

    logic signed [24:0] dn, de, dh;
    logic [24:0] an, ae;
    logic [23:0] awn, awe;
    assign dn = 25'(cfg_reg.wp_north) - 25'(pos.data.pos_north);
    assign de = 25'(cfg_reg.wp_east) - 25'(pos.data.pos_east);
    assign dh = 25'(cfg_reg.wp_alt) - 25'(pos.data.altitude);
    assign an = dn[24] ? 25'(-dn) : 25'(dn);
    assign ae = de[24] ? 25'(-de) : 25'(de);
    assign awn = cfg_reg.wp_north[23] ? 24'(-25'(cfg_reg.wp_north))
                                      : 24'(cfg_reg.wp_north);
    assign awe = cfg_reg.wp_east[23] ? 24'(-25'(cfg_reg.wp_east))
                                     : 24'(cfg_reg.wp_east);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= pos.valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sq_reg <= 52'(an * an) + 52'(ae * ae);
            a_side_reg.dn  <= 27'(dn);
            a_side_reg.de  <= 27'(de);
            a_side_reg.dh  <= 27'(dh);
            a_sq1_reg <= 52'(awn * awn) + 52'(awe * awe);
        end
    end

    // square root of the distance; a second root gives the waypoint distance
    logic   s_valid;
    logic [SQRT_STAGES-1:0] s_len;
    sideA_t s_side;
    lcg_sqrt #(.T(sideA_t)) u_sqrt_len (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(a_valid_reg), .in_val(a_sq_reg), .in_side(a_side_reg),
        .out_valid(s_valid), .out_root(s_len), .out_side(s_side)
    );
    logic [SQRT_STAGES-1:0] s_len1;
    lcg_sqrt #(.T(logic)) u_sqrt_wp (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(1'b0), .in_val(a_sq1_reg), .in_side(1'b0),
        .out_valid(), .out_root(s_len1), .out_side()
    );

    // stage B: clamped radial error times gain
    typedef struct packed {
        logic signed [YW-1:0] yaw_term;
    } sideB_t;

    logic               b_valid_reg;
    logic signed [AW:0] b_de_reg, b_dn_reg, b_dh_reg;
    logic        [SQRT_STAGES-1:0] b_len1_reg;
    logic signed [16:0] b_err_reg;

    logic signed [SQRT_STAGES+1:0] err_raw;
    logic signed [16:0] err_c;
    assign err_raw = (SQRT_STAGES+2)'(s_len) - (SQRT_STAGES+2)'(cfg_reg.orbit_radius);
    always_comb
    begin
        if (err_raw > $signed({11'd0, cfg_reg.error_limit}))
            err_c = $signed({1'b0, cfg_reg.error_limit});
        else if (err_raw < -$signed({11'd0, cfg_reg.error_limit}))
            err_c = -$signed({1'b0, cfg_reg.error_limit});
        else
            err_c = err_raw[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= s_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_de_reg   <= s_side.de;
            b_dn_reg   <= s_side.dn;
            b_dh_reg   <= s_side.dh;
            b_len1_reg <= s_len1;
            b_err_reg  <= err_c;
        end
    end

    logic signed [YW-1:0] yaw_term;
    assign yaw_term = YW'(b_err_reg * $signed({1'b0, cfg_reg.yaw_gain})) <<< 4;

    // bearing CORDIC (side carries the gain term) and pitch CORDIC
    logic c_valid;
    logic signed [AW+1:0] c_k;
    sideB_t c_side, b_side;
    assign b_side.yaw_term = yaw_term;
    lcg_cordic #(.T(sideB_t)) u_cordic_brg (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(b_valid_reg), .in_y(b_de_reg), .in_x(b_dn_reg), .in_side(b_side),
        .out_valid(c_valid), .out_ang(c_k), .out_side(c_side)
    );
    logic signed [AW+1:0] c_p;
    lcg_cordic #(.T(logic)) u_cordic_pitch (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(1'b0), .in_y(b_dh_reg), .in_x((AW+1)'(b_len1_reg)), .in_side(1'b0),
        .out_valid(), .out_ang(c_p), .out_side()
    );

    // remap to tangent heading and round
    logic signed [YW-1:0] k_map, k_yaw;
    always_comb
    begin
        if (c_k < 0)
        begin
            if (c_k > -ANG_HALF_PI)
                k_map = YW'(ANG_HALF_PI) - YW'(c_k);
            else
                k_map = YW'(ANG_HALF_PI) + YW'(ANG_PI) + YW'(c_k);
        end
        else
        begin
            if (c_k > ANG_HALF_PI)
                k_map = YW'(c_k) - YW'(ANG_HALF_PI);
            else
                k_map = YW'(ANG_HALF_PI) + YW'(c_k);
        end
        k_yaw = k_map + c_side.yaw_term;
    end

    lcg_out_t out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.yaw_cmd      <= to_q13(k_yaw);
            out_reg.pitch_cmd    <= to_q13(YW'(c_p));
            out_reg.throttle_cmd <= cfg_reg.throttle_set;
        end
    end

    assign cmd.valid = out_valid_reg;
    assign cmd.data  = out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cmd.ready) |=> $stable(out_reg))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pos.ready == (!cmd.valid || cmd.ready))
        else $error("input ready not tied to output slot");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(b_valid_reg) && $stable(a_valid_reg))
        else $error("pipeline moved during stall");
endmodule

// ===== verif/lcg_guidance_checker.sv =====
// lcg_guidance_checker: watches the position and command channels and the register port,
// predicts each command from the position request and compares. Depends on lcg_pkg, lcg_stream_if.
module lcg_guidance_checker
(
    input  logic        clk,
    input  logic        rst_n,
    lcg_stream_if       pos,
    lcg_stream_if       cmd,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    output int          failures,
    output int          pending,
    output int          checked
);
    import lcg_pkg::*;

    lcg_cfg_t regs;
    lcg_out_t expected_cmds[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC, angle in 2^-24 rad
    function automatic longint vector_angle(input longint y, input longint x);
        longint base;
        longint z;
        longint xs;
        longint ys;
        longint tab[24];
        tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
        base = 0;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            base = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
            x = -x;
            y = -y;
        end
        x = x <<< 32;
        y = y <<< 32;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + tab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - tab[i];
            end
        end
        return base + z;
    endfunction

    function automatic logic [15:0] round_q13(input longint v);
        longint r;
        r = (v + 1024) >>> 11;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic lcg_out_t predict_command(input lcg_in_t p);
        lcg_out_t o;
        longint wn, we, dn, de, dh, radial_len, wp_dist, heading, err, lim, hp, pi;
        wn = longint'(regs.wp_north);
        we = longint'(regs.wp_east);
        dn = wn - longint'(p.pos_north);
        de = we - longint'(p.pos_east);
        dh = longint'(regs.wp_alt) - longint'(p.altitude);
        hp = longint'(ANG_HALF_PI);
        pi = longint'(ANG_PI);
        radial_len = longint'(int_sqrt(dn * dn + de * de));
        wp_dist = longint'(int_sqrt(wn * wn + we * we));
        heading = vector_angle(de, dn);
        if (heading < 0)
            heading = (heading > -hp) ? hp - heading : hp + pi + heading;
        else
            heading = (heading > hp) ? heading - hp : hp + heading;
        lim = longint'(regs.error_limit);
        err = radial_len - longint'(regs.orbit_radius);
        if (err > lim)
            err = lim;
        if (err < -lim)
            err = -lim;
        heading = heading + err * longint'(regs.yaw_gain) * 16;
        o.yaw_cmd = round_q13(heading);
        o.pitch_cmd = round_q13(vector_angle(dh, wp_dist));
        o.throttle_cmd = regs.throttle_set;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        failures++;
    endtask

    assign pending = expected_cmds.size();

    always @(posedge clk or negedge rst_n)
    begin
        lcg_out_t want;
        if (!rst_n)
        begin
            regs.wp_north <= -24'sd16000;
            regs.wp_east <= 24'sd16000;
            regs.wp_alt <= 24'sd16000;
            regs.orbit_radius <= 23'd22627;
            regs.error_limit <= 16'd160;
            regs.yaw_gain <= 16'd655;
            regs.throttle_set <= 16'd45875;
            expected_cmds.delete();
            failures = 0;
            checked <= 0;
        end
        else
        begin
            if (pos.valid && pos.ready)
                expected_cmds.push_back(predict_command(pos.data));
            if (cmd.valid && cmd.ready)
            begin
                checked <= checked + 1;
                if (expected_cmds.size() == 0)
                    report_mismatch("unexpected command", 0, 0);
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd.data.yaw_cmd !== want.yaw_cmd)
                        report_mismatch("yaw_cmd", cmd.data.yaw_cmd, want.yaw_cmd);
                    if (cmd.data.pitch_cmd !== want.pitch_cmd)
                        report_mismatch("pitch_cmd", cmd.data.pitch_cmd, want.pitch_cmd);
                    if (cmd.data.throttle_cmd !== want.throttle_cmd)
                        report_mismatch("throttle_cmd", cmd.data.throttle_cmd,
                                        want.throttle_cmd);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WP_NORTH:     regs.wp_north <= cfg_wdata;
                    REG_WP_EAST:      regs.wp_east <= cfg_wdata;
                    REG_WP_ALT:       regs.wp_alt <= cfg_wdata;
                    REG_ORBIT_RADIUS: regs.orbit_radius <= cfg_wdata[22:0];
                    REG_ERROR_LIMIT:  regs.error_limit <= cfg_wdata[15:0];
                    REG_YAW_GAIN:     regs.yaw_gain <= cfg_wdata[15:0];
                    REG_THROTTLE_SET: regs.throttle_set <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/tb_loiter_circle_guidance.sv =====
// tb_loiter_circle_guidance: stimulus and verdict for the loiter circle guidance block.
// Depends on lcg_pkg, lcg_stream_if, loiter_circle_guidance, lcg_guidance_checker.
module tb_loiter_circle_guidance;
    import lcg_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wdata;
    int          failures;
    int          pending;
    int          checked;
    int          sent;
    bit          no_gaps;
    logic signed [23:0] wp_n;
    logic signed [23:0] wp_e;

    lcg_stream_if #(.T(lcg_in_t))  pos_ch ();
    lcg_stream_if #(.T(lcg_out_t)) cmd_ch ();

    loiter_circle_guidance dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos       (pos_ch.sink),
        .cmd       (cmd_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lcg_guidance_checker checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos       (pos_ch),
        .cmd       (cmd_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall before each request, bursts without stalls
    initial
    begin
        int n;
        cmd_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = no_gaps ? 0 : $urandom_range(0, 8);
            if (n > 0)
            begin
                cmd_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            cmd_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(cmd_ch.valid && cmd_ch.ready));
        end
    end

    task automatic send_position(input logic [23:0] n, input logic [23:0] e,
                                 input logic [23:0] a);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            pos_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pos_ch.data <= '{pos_north: n, pos_east: e, altitude: a};
        pos_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!(pos_ch.valid && pos_ch.ready));
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        pos_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WP_NORTH)
            wp_n = val;
        if (idx == REG_WP_EAST)
            wp_e = val;
    endtask

    // mostly near the waypoint, the rest anywhere
    task automatic random_positions(input int count);
        logic [23:0] n, e;
        for (int i = 0; i < count; i++)
        begin
            no_gaps = (i % 64) < 12;
            if ($urandom_range(0, 3) != 0)
            begin
                n = wp_n + 24'($signed($urandom_range(0, 60000)) - 30000);
                e = wp_e + 24'($signed($urandom_range(0, 60000)) - 30000);
            end
            else
            begin
                n = 24'($urandom);
                e = 24'($urandom);
            end
            send_position(n, e, 24'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        pos_ch.valid = 1'b0;
        pos_ch.data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_WP_NORTH;
        cfg_wdata = '0;
        no_gaps = 1'b0;
        sent = 0;
        wp_n = -24'sd16000;
        wp_e = 24'sd16000;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed at reset values
        send_position(wp_n, wp_e, 24'd16000);
        send_position(wp_n + 24'd100, wp_e, 24'd0);
        send_position(wp_n - 24'd100, wp_e, 24'd0);
        send_position(wp_n, wp_e + 24'd100, 24'd0);
        send_position(wp_n, wp_e - 24'd100, 24'd0);
        send_position(24'h800000, 24'h800000, 24'h800000);
        send_position(24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_position(24'h7fffff, 24'h800000, 24'h000000);
        send_position(24'h800000, 24'h7fffff, 24'hffffff);
        send_position(24'd0, 24'd0, 24'd0);
        send_position(wp_n + 24'd16000, wp_e + 24'd16000, 24'd16000);
        send_position(wp_n - 24'd22627, wp_e, 24'd5);
        drain();

        // extremes, saturating yaw, out-of-range index and oversized data
        write_reg(REG_WP_NORTH, 24'h800000);
        write_reg(REG_WP_EAST, 24'h7fffff);
        write_reg(REG_WP_ALT, 24'h800000);
        write_reg(REG_ORBIT_RADIUS, 24'hffffff);
        write_reg(REG_ERROR_LIMIT, 24'hffffff);
        write_reg(REG_YAW_GAIN, 24'hffffff);
        write_reg(REG_THROTTLE_SET, 24'hffffff);
        write_reg(REG_UNUSED, 24'h123456);
        send_position(24'h7fffff, 24'h800000, 24'h7fffff);
        send_position(24'h800000, 24'h7fffff, 24'h800000);
        send_position(24'h7fffff, 24'h7fffff, 24'h000000);
        send_position(24'h000000, 24'h000000, 24'h7fffff);
        random_positions(150);
        drain();

        write_reg(REG_ORBIT_RADIUS, 24'd0);
        write_reg(REG_ERROR_LIMIT, 24'd0);
        write_reg(REG_YAW_GAIN, 24'd0);
        write_reg(REG_THROTTLE_SET, 24'd0);
        write_reg(REG_WP_NORTH, 24'd0);
        write_reg(REG_WP_EAST, 24'd0);
        write_reg(REG_WP_ALT, 24'h7fffff);
        send_position(24'd0, 24'd0, 24'd0);
        send_position(24'd50, 24'd0, 24'd0);
        random_positions(150);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_WP_NORTH,
                      24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 40000)));
            write_reg(REG_WP_EAST,
                      24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 40000)));
            write_reg(REG_WP_ALT, 24'($urandom));
            write_reg(REG_ORBIT_RADIUS, 24'($urandom_range(0, 30000)));
            write_reg(REG_ERROR_LIMIT, 24'($urandom_range(0, 2000)));
            write_reg(REG_YAW_GAIN, 24'($urandom_range(0, 65535)));
            write_reg(REG_THROTTLE_SET, 24'($urandom));
            random_positions(125);
            drain();
        end

        $display("sent %0d position requests over seven register settings, %0d commands checked",
                 sent, checked);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lcg_pkg.sv
sv/lcg_stream_if.sv
sv/lcg_sqrt.sv
sv/lcg_cordic.sv
sv/loiter_circle_guidance.sv
verif/lcg_guidance_checker.sv
verif/tb_loiter_circle_guidance.sv
